/* rtl/bstk_pkg.sv */
package bstk_pkg;

    // Stack geometry
    localparam int DEPTH  = 8;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);

    // Field widths fixed by the request and response formats
    localparam int MODE_W = 2;
    localparam int POS_W  = 4;
    localparam int WORD_W = 32;
    localparam int STAT_W = 2;

    // Width used to compare a position against the fill count
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    typedef enum logic [MODE_W-1:0] {
        MODE_PUSH   = 2'd0,
        MODE_POP    = 2'd1,
        MODE_PEEK   = 2'd2,
        MODE_CHANGE = 2'd3
    } mode_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_OVERFLOW  = 2'd1,
        STAT_UNDERFLOW = 2'd2,
        STAT_BADPOS    = 2'd3
    } status_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_RESP = 1'b1
    } state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic exec;  // request transfer: check, access memory, update count
        logic load;  // move the pending result into the output register
    } cmd_t;

endpackage

/* rtl/bstk_req_if.sv */
interface bstk_req_if;

    logic                                valid;
    logic                                ready;
    logic [bstk_pkg::MODE_W-1:0]         mode;
    logic [bstk_pkg::POS_W-1:0]          position;
    logic signed [bstk_pkg::WORD_W-1:0]  value;

    modport source (output valid, output mode, output position, output value, input ready);
    modport sink   (input valid, input mode, input position, input value, output ready);

endinterface

/* rtl/bstk_rsp_if.sv */
interface bstk_rsp_if;

    logic                                valid;
    logic                                ready;
    logic [bstk_pkg::STAT_W-1:0]         status;
    logic signed [bstk_pkg::WORD_W-1:0]  data;
    logic [bstk_pkg::POS_W-1:0]          count;

    modport source (output valid, output status, output data, output count, input ready);
    modport sink   (input valid, input status, input data, input count, output ready);

endinterface

/* rtl/bounded_stack_with_indexed_access.sv */
// LIFO stack of signed 32-bit words, bstk_pkg::DEPTH entries deep, with push,
// pop, peek and change at a position counted from the top (1 is the top).
// Every request transfer gives exactly one response: status, the word read
// (zero unless a pop or peek succeeds) and the fill count afterwards. A request
// is checked, the fill count updated and the entry RAM accessed in the idle state;
// in the response state the registered RAM read moves into the output register
// once that register is free, and only then is the next request taken.
// The block is ready straight after reset with an empty stack; the entry RAM
// is not cleared, and no entry is read before it has been written.
module bounded_stack_with_indexed_access (
    input  logic        clk,
    input  logic        rst_n,
    bstk_req_if.sink    req,
    bstk_rsp_if.source  rsp
);

    bstk_pkg::cmd_t cmd;
    logic           in_ready;
    logic           out_valid;

    // Sequencing of request and response transfers
    bstk_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (rsp.ready),
        .cmd       (cmd)
    );

    // Stack store, fill count and result registers
    bstk_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .mode     (req.mode),
        .position (req.position),
        .value    (req.value),
        .status   (rsp.status),
        .data     (rsp.data),
        .count    (rsp.count)
    );

    assign req.ready = in_ready;
    assign rsp.valid = out_valid;

endmodule

/* rtl/bstk_ram.sv */
module bstk_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic                                    re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Single write port, registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/bstk_ctrl.sv */
module bstk_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output bstk_pkg::cmd_t    cmd
);

    bstk_pkg::state_t state_reg, state_next;
    logic             out_valid_reg, out_valid_next;
    logic             out_free;

    // Output register can take a new result this cycle
    assign out_free = !out_valid_reg || out_ready;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bstk_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = bstk_pkg::ST_RESP;
                end
            end
            bstk_pkg::ST_RESP:
            begin
                if (out_free)
                begin
                    state_next = bstk_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bstk_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs and commands
    always_comb
    begin
        in_ready = 1'b0;
        cmd      = '0;
        unique case (state_reg)
            bstk_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.exec = in_valid;
            end
            bstk_pkg::ST_RESP:
            begin
                cmd.load = out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // Output valid flag
    always_comb
    begin
        priority if (cmd.load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bstk_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

/* rtl/bstk_dp.sv */
module bstk_dp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  bstk_pkg::cmd_t                      cmd,
    input  logic [bstk_pkg::MODE_W-1:0]         mode,
    input  logic [bstk_pkg::POS_W-1:0]          position,
    input  logic signed [bstk_pkg::WORD_W-1:0]  value,
    output logic [bstk_pkg::STAT_W-1:0]         status,
    output logic signed [bstk_pkg::WORD_W-1:0]  data,
    output logic [bstk_pkg::POS_W-1:0]          count
);

    localparam int AW = bstk_pkg::ADDR_W;
    localparam int CW = bstk_pkg::CNT_W;
    localparam int XW = bstk_pkg::CMP_W;

    logic [CW-1:0]                count_reg, count_next;
    bstk_pkg::status_t            pend_status_reg, pend_status_next;
    logic                         pend_rd_ok_reg, pend_rd_ok_next;
    bstk_pkg::status_t            out_status_reg;
    logic [bstk_pkg::WORD_W-1:0]  out_data_reg;
    logic [bstk_pkg::POS_W-1:0]   out_count_reg;

    logic                         full, empty;
    logic [XW-1:0]                count_wide, pos_wide, slot_wide;
    logic                         we, re;
    logic [AW-1:0]                waddr, raddr;
    logic [bstk_pkg::WORD_W-1:0]  rdata;

    assign full       = (count_reg == CW'(bstk_pkg::DEPTH));
    assign empty      = (count_reg == '0);
    assign count_wide = XW'(count_reg);
    assign pos_wide   = XW'(position);
    assign slot_wide  = count_wide - pos_wide;

    // Request decode: status, memory access and new fill count
    always_comb
    begin
        count_next       = count_reg;
        pend_status_next = bstk_pkg::STAT_OK;
        pend_rd_ok_next  = 1'b0;
        we               = 1'b0;
        re               = 1'b0;
        waddr            = count_reg[AW-1:0];
        raddr            = slot_wide[AW-1:0];
        unique case (bstk_pkg::mode_t'(mode))
            bstk_pkg::MODE_PUSH:
            begin
                if (full)
                begin
                    pend_status_next = bstk_pkg::STAT_OVERFLOW;
                end
                else
                begin
                    we         = cmd.exec;
                    count_next = count_reg + CW'(1);
                end
            end
            bstk_pkg::MODE_POP:
            begin
                if (empty)
                begin
                    pend_status_next = bstk_pkg::STAT_UNDERFLOW;
                end
                else
                begin
                    count_next      = count_reg - CW'(1);
                    raddr           = count_next[AW-1:0];
                    re              = cmd.exec;
                    pend_rd_ok_next = 1'b1;
                end
            end
            bstk_pkg::MODE_PEEK, bstk_pkg::MODE_CHANGE:
            begin
                priority if (empty)
                begin
                    pend_status_next = bstk_pkg::STAT_UNDERFLOW;
                end
                else if (pos_wide == '0 || pos_wide > count_wide)
                begin
                    pend_status_next = bstk_pkg::STAT_BADPOS;
                end
                else if (bstk_pkg::mode_t'(mode) == bstk_pkg::MODE_PEEK)
                begin
                    re              = cmd.exec;
                    pend_rd_ok_next = 1'b1;
                end
                else
                begin
                    waddr = slot_wide[AW-1:0];
                    we    = cmd.exec;
                end
            end
            default:
            begin
                pend_status_next = bstk_pkg::STAT_OK;
            end
        endcase
    end

    // Entry store
    bstk_ram #(
        .WIDTH (bstk_pkg::WORD_W),
        .DEPTH (bstk_pkg::DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (value),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata)
    );

    // Fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.exec)
        begin
            count_reg <= count_next;
        end
    end

    // Pending result, held until the output register is free
    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            pend_status_reg <= pend_status_next;
            pend_rd_ok_reg  <= pend_rd_ok_next;
        end
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            out_status_reg <= pend_status_reg;
            out_data_reg   <= pend_rd_ok_reg ? rdata : '0;
            out_count_reg  <= count_wide[bstk_pkg::POS_W-1:0];
        end
    end

    assign status = out_status_reg;
    assign data   = out_data_reg;
    assign count  = out_count_reg;

endmodule
